@@ design/sid_pkg.sv @@
package sid_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W  = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_SORT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd5;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [IDX_W-1:0]        idx_t;

endpackage

@@ design/sorted_insert_deque.sv @@
// Ordered store of up to sid_pkg::CAPACITY signed 32-bit entries.
// Input channel (in_valid / in_stall) carries one command beat: in_command,
// in_value (push commands) and in_position (read). Output channel
// (out_valid / out_stall) returns exactly one beat per command: out_status,
// out_read_value, and out_front_value, out_back_value, out_fill_count as
// they stand after the command.
// Commands run one at a time; in_stall is high from acceptance until the
// result is loaded into the output register. All entry traffic goes through
// the single read port and single write port of the entry memory, so an
// entry move takes a read step and then a write step.
// A sorted push compares the value with the front entry, then the back
// entry, then scans upward from index 1 for the first entry not below it.
// Pushes shift the entries at and above the slot up one place from the back
// before writing the value; pop front shifts entries down toward the front.
// Every command ends by reading the front and back entries (skipped when the
// store is empty) and then loads the output register.
// When out_stall holds the output, a finished command waits in its last step
// and the block takes no new beat; the held result does not change.
// Synchronous active-low reset empties the store and drops any pending
// result; entry contents are not cleared, only the fill count.
module sorted_insert_deque (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sid_pkg::CMD_W-1:0]       in_command,
  input  logic signed [sid_pkg::VAL_W-1:0] in_value,
  input  logic [sid_pkg::POS_W-1:0]       in_position,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sid_pkg::STAT_W-1:0]      out_status,
  output logic signed [sid_pkg::VAL_W-1:0] out_read_value,
  output logic signed [sid_pkg::VAL_W-1:0] out_front_value,
  output logic signed [sid_pkg::VAL_W-1:0] out_back_value,
  output logic [sid_pkg::FILL_W-1:0]      out_fill_count
);
  import sid_pkg::*;

  localparam int SW = 5;
  localparam logic [SW-1:0] S_IDLE     = 5'd0;
  localparam logic [SW-1:0] S_SRT0     = 5'd1;
  localparam logic [SW-1:0] S_SRT0_CMP = 5'd2;
  localparam logic [SW-1:0] S_SRTL     = 5'd3;
  localparam logic [SW-1:0] S_SRTL_CMP = 5'd4;
  localparam logic [SW-1:0] S_SRTS     = 5'd5;
  localparam logic [SW-1:0] S_SRTS_CMP = 5'd6;
  localparam logic [SW-1:0] S_INS_CHK  = 5'd7;
  localparam logic [SW-1:0] S_INS_MOV  = 5'd8;
  localparam logic [SW-1:0] S_INS_WR   = 5'd9;
  localparam logic [SW-1:0] S_POPF     = 5'd10;
  localparam logic [SW-1:0] S_POPF_MOV = 5'd11;
  localparam logic [SW-1:0] S_READ     = 5'd12;
  localparam logic [SW-1:0] S_READ_GET = 5'd13;
  localparam logic [SW-1:0] S_FIN0     = 5'd14;
  localparam logic [SW-1:0] S_FIN1     = 5'd15;
  localparam logic [SW-1:0] S_FIN2     = 5'd16;
  localparam logic [SW-1:0] S_OUT      = 5'd17;

  val_t mem [CAPACITY];

  logic [SW-1:0]     state_r, state_nxt;
  cnt_t              cnt_r, cnt_nxt;
  cnt_t              i_r, i_nxt;
  cnt_t              slot_r, slot_nxt;
  val_t              val_r, val_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  val_t              rd_r, rd_nxt;
  val_t              front_r, front_nxt;
  val_t              back_r, back_nxt;
  val_t              rd_data_r;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  val_t              out_rd_r, out_rd_nxt;
  val_t              out_front_r, out_front_nxt;
  val_t              out_back_r, out_back_nxt;
  cnt_t              out_cnt_r, out_cnt_nxt;

  idx_t rd_addr;
  idx_t wr_addr;
  logic wr_en;
  val_t wr_data;
  logic in_acc;
  logic full;
  logic v_lt;
  logic v_eq;
  cnt_t cnt_m1;
  cnt_t i_m1;
  cnt_t i_p1;

  assign in_acc = in_valid && !in_stall;
  assign full   = (cnt_r >= CNT_W'(CAPACITY));
  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign i_m1   = i_r - CNT_W'(1);
  assign i_p1   = i_r + CNT_W'(1);

  // Shared compare of the command value against the word just read.
  assign v_lt = (val_r < rd_data_r);
  assign v_eq = (val_r == rd_data_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    slot_nxt       = slot_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    stat_nxt       = stat_r;
    rd_nxt         = rd_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    out_front_nxt  = out_front_r;
    out_back_nxt   = out_back_r;
    out_cnt_nxt    = out_cnt_r;
    rd_addr        = '0;
    wr_addr        = i_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_data        = rd_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          val_nxt  = in_value;
          pos_nxt  = in_position;
          stat_nxt = ST_DONE;
          rd_nxt   = '0;
          i_nxt    = cnt_r;
          state_nxt = S_FIN0;
          case (in_command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_PUSH_SORT: begin
              if (full) begin
                stat_nxt = ST_FULL;
              end else if (in_command == CMD_PUSH_FRONT) begin
                slot_nxt  = '0;
                state_nxt = S_INS_CHK;
              end else if (in_command == CMD_PUSH_BACK || cnt_r == '0) begin
                slot_nxt  = (in_command == CMD_PUSH_BACK) ? cnt_r : '0;
                state_nxt = S_INS_CHK;
              end else begin
                state_nxt = S_SRT0;
              end
            end
            CMD_POP_FRONT: begin
              if (cnt_r == '0) begin
                stat_nxt = ST_EMPTY;
              end else begin
                i_nxt     = '0;
                state_nxt = S_POPF;
              end
            end
            CMD_POP_BACK: begin
              if (cnt_r == '0) begin
                stat_nxt = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_m1;
              end
            end
            CMD_READ: begin
              if (CNT_W'(in_position) < cnt_r) begin
                state_nxt = S_READ;
              end else begin
                stat_nxt = ST_RANGE;
              end
            end
            default: begin
              state_nxt = S_FIN0;
            end
          endcase
        end
      end
      S_SRT0: begin
        rd_addr   = '0;
        state_nxt = S_SRT0_CMP;
      end
      S_SRT0_CMP: begin
        if (v_lt || v_eq) begin
          slot_nxt  = '0;
          i_nxt     = cnt_r;
          state_nxt = S_INS_CHK;
        end else begin
          state_nxt = S_SRTL;
        end
      end
      S_SRTL: begin
        rd_addr   = cnt_m1[IDX_W-1:0];
        state_nxt = S_SRTL_CMP;
      end
      S_SRTL_CMP: begin
        if (!v_lt) begin
          slot_nxt  = cnt_r;
          i_nxt     = cnt_r;
          state_nxt = S_INS_CHK;
        end else begin
          i_nxt     = CNT_W'(1);
          state_nxt = S_SRTS;
        end
      end
      S_SRTS: begin
        rd_addr   = i_r[IDX_W-1:0];
        state_nxt = S_SRTS_CMP;
      end
      S_SRTS_CMP: begin
        // Last entry is known to be above the value, so the scan ends there.
        if (v_lt || v_eq) begin
          slot_nxt  = i_r;
          i_nxt     = cnt_r;
          state_nxt = S_INS_CHK;
        end else begin
          i_nxt     = i_p1;
          state_nxt = S_SRTS;
        end
      end
      S_INS_CHK: begin
        rd_addr = i_m1[IDX_W-1:0];
        if (i_r > slot_r) begin
          state_nxt = S_INS_MOV;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_MOV: begin
        wr_en     = 1'b1;
        wr_addr   = i_r[IDX_W-1:0];
        wr_data   = rd_data_r;
        i_nxt     = i_m1;
        state_nxt = S_INS_CHK;
      end
      S_INS_WR: begin
        wr_en     = 1'b1;
        wr_addr   = slot_r[IDX_W-1:0];
        wr_data   = val_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_FIN0;
      end
      S_POPF: begin
        rd_addr = i_p1[IDX_W-1:0];
        if (i_p1 < cnt_r) begin
          state_nxt = S_POPF_MOV;
        end else begin
          cnt_nxt   = cnt_m1;
          state_nxt = S_FIN0;
        end
      end
      S_POPF_MOV: begin
        wr_en     = 1'b1;
        wr_addr   = i_r[IDX_W-1:0];
        wr_data   = rd_data_r;
        i_nxt     = i_p1;
        state_nxt = S_POPF;
      end
      S_READ: begin
        rd_addr   = IDX_W'(pos_r);
        state_nxt = S_READ_GET;
      end
      S_READ_GET: begin
        rd_nxt    = rd_data_r;
        state_nxt = S_FIN0;
      end
      S_FIN0: begin
        rd_addr = '0;
        if (cnt_r == '0) begin
          front_nxt = '0;
          back_nxt  = '0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_FIN1;
        end
      end
      S_FIN1: begin
        rd_addr   = cnt_m1[IDX_W-1:0];
        front_nxt = rd_data_r;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        back_nxt  = rd_data_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Hold here until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_rd_nxt     = rd_r;
          out_front_nxt  = front_r;
          out_back_nxt   = back_r;
          out_cnt_nxt    = cnt_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    slot_r       <= slot_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    stat_r       <= stat_nxt;
    rd_r         <= rd_nxt;
    front_r      <= front_nxt;
    back_r       <= back_nxt;
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_front_r  <= out_front_nxt;
    out_back_r   <= out_back_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_rd_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;
  assign out_fill_count  = FILL_W'(out_cnt_r);

endmodule

@@ verif/sorted_insert_deque_checker.sv @@
`timescale 1ns / 1ps

module sorted_insert_deque_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [sid_pkg::CMD_W-1:0]         in_command,
  input  logic signed [sid_pkg::VAL_W-1:0]  in_value,
  input  logic [sid_pkg::POS_W-1:0]         in_position,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [sid_pkg::STAT_W-1:0]        out_status,
  input  logic signed [sid_pkg::VAL_W-1:0]  out_read_value,
  input  logic signed [sid_pkg::VAL_W-1:0]  out_front_value,
  input  logic signed [sid_pkg::VAL_W-1:0]  out_back_value,
  input  logic [sid_pkg::FILL_W-1:0]        out_fill_count,
  output int                                fail_count,
  output int                                pending_count
);
  import sid_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    val_t              read_value;
    val_t              front_value;
    val_t              back_value;
    logic [FILL_W-1:0] fill;
  } deque_result_t;

  val_t          shadow_entries [CAPACITY];
  int            shadow_fill = 0;
  deque_result_t expected_results [$];
  int            mismatches = 0;
  int            depth = 0;

  assign fail_count    = mismatches;
  assign pending_count = depth;

  initial begin
    foreach (shadow_entries[i]) shadow_entries[i] = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Apply one command to the shadow deque and return the beat it should produce.
  task automatic apply_command(input logic [CMD_W-1:0] cmd, input val_t v,
                               input logic [POS_W-1:0] pos, output deque_result_t r);
    int slot;
    r.status     = ST_DONE;
    r.read_value = '0;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_PUSH_SORT: begin
        if (shadow_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            slot = 0;
          end else if (cmd == CMD_PUSH_BACK) begin
            slot = shadow_fill;
          end else if (shadow_fill == 0 || v <= shadow_entries[0]) begin
            slot = 0;
          end else if (v >= shadow_entries[shadow_fill-1]) begin
            slot = shadow_fill;
          end else begin
            // scan down so the first not-smaller entry after the head wins
            slot = shadow_fill;
            for (int i = shadow_fill - 1; i >= 1; i--)
              if (shadow_entries[i] >= v) slot = i;
          end
          for (int i = shadow_fill; i > slot; i--)
            shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[slot] = v;
          shadow_fill++;
        end
      end
      CMD_POP_FRONT: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i + 1 < shadow_fill; i++)
            shadow_entries[i] = shadow_entries[i+1];
          shadow_fill--;
        end
      end
      CMD_POP_BACK: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else shadow_fill--;
      end
      CMD_READ: begin
        if (int'(pos) < shadow_fill) r.read_value = shadow_entries[pos];
        else r.status = ST_RANGE;
      end
      default: ;
    endcase
    r.front_value = (shadow_fill > 0) ? shadow_entries[0] : '0;
    r.back_value  = (shadow_fill > 0) ? shadow_entries[shadow_fill-1] : '0;
    r.fill        = shadow_fill[FILL_W-1:0];
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      expected_results.delete();
      shadow_fill = 0;
    end else begin
      // compare first: a result beat always belongs to an older command
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat status=%0d fill=%0d",
                                    out_status, out_fill_count));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_status, want.status));
          if (out_read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %0d expected %0d",
                                      out_read_value, want.read_value));
          if (out_front_value !== want.front_value)
            report_mismatch($sformatf("front_value got %0d expected %0d",
                                      out_front_value, want.front_value));
          if (out_back_value !== want.back_value)
            report_mismatch($sformatf("back_value got %0d expected %0d",
                                      out_back_value, want.back_value));
          if (out_fill_count !== want.fill)
            report_mismatch($sformatf("fill_count got %0d expected %0d",
                                      out_fill_count, want.fill));
        end
      end
      if (in_valid && !in_stall) begin
        apply_command(in_command, in_value, in_position, want);
        expected_results.push_back(want);
      end
    end
    depth = expected_results.size();
  end

endmodule

@@ verif/sorted_insert_deque_tb.sv @@
`timescale 1ns / 1ps

module sorted_insert_deque_tb;
  import sid_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam int STALL_NONE   = 0;
  localparam int STALL_RANDOM = 1;
  localparam int STALL_LONG   = 2;
  localparam int STALL_TOGGLE = 3;

  localparam val_t VAL_MIN = 32'sh8000_0000;
  localparam val_t VAL_MAX = 32'sh7fff_ffff;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command;
  val_t                in_value;
  logic [POS_W-1:0]    in_position;
  logic                out_valid;
  logic                out_stall;
  logic [STAT_W-1:0]   out_status;
  val_t                out_read_value;
  val_t                out_front_value;
  val_t                out_back_value;
  logic [FILL_W-1:0]   out_fill_count;

  int fail_count;
  int pending_count;
  int quiet_cycles = 0;
  int burst_left   = 0;

  sorted_insert_deque dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_fill_count  (out_fill_count)
  );

  sorted_insert_deque_checker scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_fill_count  (out_fill_count),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mix tight clusters (to hit equal keys), extremes and full-range values.
  function automatic val_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: pick_value = $signed($urandom_range(0, 16)) - 8;
      3: begin
        case ($urandom_range(0, 3))
          0: pick_value = VAL_MIN;
          1: pick_value = VAL_MAX;
          2: pick_value = '0;
          default: pick_value = -1;
        endcase
      end
      default: pick_value = $urandom;
    endcase
  endfunction

  // Send one command beat, inserting a random gap between bursts.
  task automatic issue(input logic [CMD_W-1:0] cmd, input val_t v,
                       input logic [POS_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_value    <= v;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Result-side backpressure, independent of the sender.
  initial begin
    int mode;
    int left;
    int pct;
    out_stall = 1'b0;
    left = 0;
    mode = STALL_NONE;
    pct  = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(STALL_NONE, STALL_TOGGLE);
        pct  = $urandom_range(10, 80);
        case (mode)
          STALL_NONE:   left = $urandom_range(10, 150);
          STALL_LONG:   left = $urandom_range(1, 30);
          default:      left = $urandom_range(10, 80);
        endcase
      end
      left--;
      case (mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= ($urandom_range(1, 100) <= pct);
        STALL_LONG:   out_stall <= 1'b1;
        default:      out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int issued;
    int segment_left;
    int push_pct;
    int roll;
    logic [CMD_W-1:0] cmd;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_command  = CMD_PUSH_FRONT;
    in_value    = '0;
    in_position = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty store, unused codes, ordering corners, full store
    issue(CMD_POP_FRONT, '0, '0);
    issue(CMD_POP_BACK, '0, '0);
    issue(CMD_READ, '0, 4'd0);
    issue(CMD_SPARE_A, 32'sd123, 4'd3);
    issue(CMD_SPARE_B, -32'sd1, 4'd15);
    issue(CMD_PUSH_SORT, 32'sd0, '0);
    issue(CMD_PUSH_FRONT, VAL_MIN, '0);
    issue(CMD_PUSH_BACK, VAL_MAX, '0);
    issue(CMD_PUSH_SORT, -32'sd5, '0);
    issue(CMD_PUSH_SORT, VAL_MIN, '0);
    issue(CMD_PUSH_SORT, VAL_MAX, '0);
    issue(CMD_PUSH_SORT, 32'sd0, '0);
    issue(CMD_READ, '0, 4'd15);
    issue(CMD_READ, '0, 4'd0);
    repeat (CAPACITY - 7) issue(CMD_PUSH_SORT, pick_value(), '0);
    issue(CMD_PUSH_FRONT, VAL_MAX, '0);
    issue(CMD_PUSH_BACK, VAL_MIN, '0);
    issue(CMD_PUSH_SORT, 32'sd1, '0);
    issue(CMD_READ, '0, 4'd15);

    // random: segments lean toward filling or draining so the fill level sweeps
    issued       = 0;
    segment_left = 0;
    push_pct     = 50;
    while (issued < RANDOM_ITEMS) begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: push_pct = 75;
          1: push_pct = 25;
          default: push_pct = 50;
        endcase
      end
      segment_left--;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
      end else if ($urandom_range(1, 100) <= push_pct) begin
        case ($urandom_range(0, 3))
          0: cmd = CMD_PUSH_FRONT;
          1: cmd = CMD_PUSH_BACK;
          default: cmd = CMD_PUSH_SORT;
        endcase
      end else begin
        case ($urandom_range(0, 4))
          0: cmd = CMD_POP_FRONT;
          1: cmd = CMD_POP_BACK;
          default: cmd = CMD_READ;
        endcase
      end
      issue(cmd, pick_value(), POS_W'($urandom_range(0, 15)));
      if (cmd != CMD_SPARE_A && cmd != CMD_SPARE_B) issued++;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/sid_pkg.sv
design/sorted_insert_deque.sv
verif/sorted_insert_deque_checker.sv
verif/sorted_insert_deque_tb.sv
